### src/tap_and_midi_tempo_tracker_macros.svh
// ----------------------------------------------------------------------------
// tempo tracker assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TAP_AND_MIDI_TEMPO_TRACKER_MACROS_SVH
`define TAP_AND_MIDI_TEMPO_TRACKER_MACROS_SVH

// same-cycle implication
`define TMT_ASSERT_NOW(label, clk, rst, cond, body) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (body)) \
    else $error("tempo tracker check failed");

// next-cycle implication
`define TMT_ASSERT_NEXT(label, clk, rst, cond, body) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (body)) \
    else $error("tempo tracker check failed");

`endif

### src/tmt_pkg.sv
// ----------------------------------------------------------------------------
// tmt_pkg
// shared types, constants and width helpers of the tempo tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmt_pkg;

  localparam int AVG_DEPTH_DEF = 4;
  localparam int TAP_W         = 12;
  localparam int PERIOD_W      = 21;
  localparam int TS_W          = 32;
  localparam int TALLY_W       = 7;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int MUL_W         = 32;
  localparam int MID_W         = 36;
  localparam int TAP_SHIFT     = 24;
  localparam int MS_SHIFT      = 40;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 21'h0FFFFF;
  localparam logic [8:0]          ROUND_US     = 9'd500;
  // ceil(2^40 / 1000), exact below the saturation point
  localparam logic [MUL_W-1:0]    MS_RECIP     = 32'd1099511628;
  // smallest rounded clock dividend whose quotient exceeds PERIOD_MAX
  localparam logic [MID_W-1:0]    SAT_DIVIDEND = 36'd1048576000;

  localparam logic [11:0] MIN_TAP_RST = 12'd60;
  localparam logic [11:0] MAX_TAP_RST = 12'd2000;
  localparam logic [15:0] DECAY_RST   = 16'd2500;
  localparam logic [23:0] TIMEOUT_RST = 24'd2000000;
  localparam logic [6:0]  CPB_RST     = 7'd24;

  typedef enum logic [2:0] {
    OP_TAP   = 3'd0,
    OP_CLOCK = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_POT   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SRC_TAP  = 2'd0,
    SRC_MIDI = 2'd1,
    SRC_POT  = 2'd2
  } src_t;

  typedef enum logic [2:0] {
    REG_MIN_TAP = 3'd0,
    REG_MAX_TAP = 3'd1,
    REG_DECAY   = 3'd2,
    REG_TIMEOUT = 3'd3,
    REG_CPB     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] min_tap_ms;
    logic [11:0] max_tap_ms;
    logic [15:0] decay_ms;
    logic [23:0] clock_timeout_us;
    logic [6:0]  clocks_per_beat;
  } cfg_t;

  function automatic int fill_width(input int depth);
    return $clog2(depth + 1);
  endfunction

  function automatic int sum_width(input int depth);
    return $clog2(depth * ((1 << TAP_W) - 1) + 1);
  endfunction

  // ceil(2^TAP_SHIFT / d) for a constant count d
  function automatic logic [MUL_W-1:0] recip_of(input int d);
    return MUL_W'(((64'd1 << TAP_SHIFT) + 64'(d) - 64'd1) / 64'(d));
  endfunction

endpackage

### src/tap_and_midi_tempo_tracker.sv
// ----------------------------------------------------------------------------
// tap_and_midi_tempo_tracker
// tempo tracker for footswitch taps, midi clock and a tempo pot
// ----------------------------------------------------------------------------
// s_* channel takes one event request: s_tuser is the event code, s_tdata
//   carries both timestamps, the footswitch level and the pot period
// m_* channel gives at most one new period per event, source in m_tuser
// apb port sets tap limits, decay, clock timeout and clocks per beat
// one event at a time, s_tready is low while an event is worked on:
//   start, stop and taps with no new interval end in S_DISPATCH, a clock that
//   closes no window in S_CLK_WIN and an out of range interval in
//   S_TAP_RANGE; a pot result goes from S_DISPATCH straight to S_EMIT
// a tap mean or a closed clock window goes through the shared reciprocal
//   multiplier by way of S_TAP_MEAN or S_CLK_DIV, then S_DIV_WAIT and
//   S_EMIT, which sets the worst-case rate
// synchronous rst clears tap history, clock window and external latch,
//   loads the default settings and holds s_tready low
// a result waits in the output register while m_tready is low; the next
//   event is still accepted, and only a new result waits for the register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tap_and_midi_tempo_tracker #(
  parameter int AVG_DEPTH = tmt_pkg::AVG_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [87:0]                 s_tdata,  // now_ms, now_us, tap_level, pot_period
  input  logic [2:0]                  s_tuser,  // operation
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,  // period
  output logic [1:0]                  m_tuser,  // source
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmt_pkg::ADDR_W-1:0]  paddr,
  input  logic [tmt_pkg::DATA_W-1:0]  pwdata,
  output logic [tmt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int TS_W     = tmt_pkg::TS_W;
  localparam int PERIOD_W = tmt_pkg::PERIOD_W;
  localparam int TALLY_W  = tmt_pkg::TALLY_W;
  localparam int MUL_W    = tmt_pkg::MUL_W;
  localparam int MID_W    = tmt_pkg::MID_W;
  localparam int TAP_W    = tmt_pkg::TAP_W;
  localparam int SUM_W    = tmt_pkg::sum_width(AVG_DEPTH);
  localparam int FILL_W   = tmt_pkg::fill_width(AVG_DEPTH);
  localparam int TAPX_W   = SUM_W + 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_TAP_RANGE,
    S_TAP_MEAN,
    S_CLK_WIN,
    S_CLK_DIV,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  state_t                 state;
  tmt_pkg::cfg_t          cfg;

  tmt_pkg::op_t           op_q;
  logic [TS_W-1:0]        now_ms_q;
  logic [TS_W-1:0]        now_us_q;
  logic                   level_q;
  logic [PERIOD_W-1:0]    pot_q;

  logic [TS_W-1:0]        last_tap;
  logic                   prev_level;
  logic                   latched;
  logic [TS_W-1:0]        last_ext;
  logic [TS_W-1:0]        win_start;
  logic [TS_W-1:0]        last_clk;
  logic [TALLY_W-1:0]     tally;
  logic [TS_W-1:0]        interval_q;
  logic [TS_W-1:0]        elapsed_q;
  logic [PERIOD_W-1:0]    period_q;
  tmt_pkg::src_t          src_q;

  logic                   out_of_range;
  logic                   avg_clear;
  logic                   avg_write;
  logic [SUM_W-1:0]       avg_sum;
  logic [FILL_W-1:0]      avg_fill;

  logic                   div_start;
  logic                   div_wide;
  logic                   div_sat;
  logic [MUL_W-1:0]       div_dividend;
  logic [MUL_W-1:0]       div_recip;
  logic                   div_done;
  logic [PERIOD_W-1:0]    div_quo;
  logic [MID_W-1:0]       mid_x;
  logic [TAPX_W-1:0]      tap_x;
  logic [MUL_W-1:0]       tap_recip;

  logic                   clk_timeout;
  logic [TALLY_W-1:0]     tally_eff;
  logic                   pot_hold;

  assign s_tready = (state == S_IDLE) && !rst;

  assign out_of_range = (interval_q < TS_W'(cfg.min_tap_ms)) ||
                        (interval_q > TS_W'(cfg.max_tap_ms));
  assign avg_clear    = (state == S_TAP_RANGE) && out_of_range;
  assign avg_write    = (state == S_TAP_RANGE) && !out_of_range;

  assign div_start    = (state == S_TAP_MEAN) || (state == S_CLK_DIV);
  assign div_wide     = (state == S_CLK_DIV);
  assign mid_x        = {elapsed_q, 4'b0000} + MID_W'(tmt_pkg::ROUND_US);
  assign tap_x        = {avg_sum, 4'b0000} + TAPX_W'(avg_fill >> 1);
  assign div_sat      = div_wide && (mid_x >= tmt_pkg::SAT_DIVIDEND);
  assign div_dividend = div_wide ? mid_x[MUL_W-1:0] : MUL_W'(tap_x);
  assign div_recip    = div_wide ? tmt_pkg::MS_RECIP : tap_recip;

  always_comb begin
    tap_recip = '0;
    for (int d = 1; d <= AVG_DEPTH; d++) begin
      if (avg_fill == FILL_W'(d)) begin
        tap_recip = tmt_pkg::recip_of(d);
      end
    end
  end

  assign clk_timeout  = (last_clk != '0) &&
                        ((now_us_q - last_clk) > TS_W'(cfg.clock_timeout_us));
  assign tally_eff    = clk_timeout ? '0 : tally;
  assign pot_hold     = latched && ((now_ms_q - last_ext) <= TS_W'(cfg.decay_ms));

  tmt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmt_avg #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_avg (
    .clk      (clk),
    .rst      (rst),
    .clear    (avg_clear),
    .write    (avg_write),
    .interval (interval_q[TAP_W-1:0]),
    .sum      (avg_sum),
    .fill     (avg_fill)
  );

  tmt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .wide     (div_wide),
    .sat      (div_sat),
    .dividend (div_dividend),
    .recip    (div_recip),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      last_tap   <= '0;
      prev_level <= 1'b1;
      latched    <= 1'b0;
      last_ext   <= '0;
      win_start  <= '0;
      last_clk   <= '0;
      tally      <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q     <= tmt_pkg::op_t'(s_tuser);
            now_ms_q <= s_tdata[31:0];
            now_us_q <= s_tdata[63:32];
            level_q  <= s_tdata[64];
            pot_q    <= s_tdata[85:65];
            state    <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (op_q)
            tmt_pkg::OP_TAP: begin
              prev_level <= level_q;
              if (prev_level && !level_q) begin
                last_tap <= now_ms_q;
                if (last_tap != '0) begin
                  interval_q <= now_ms_q - last_tap;
                  state      <= S_TAP_RANGE;
                end else begin
                  state <= S_IDLE;
                end
              end else begin
                state <= S_IDLE;
              end
            end
            tmt_pkg::OP_CLOCK: begin
              last_clk <= now_us_q;
              if (tally_eff == '0) begin
                win_start <= now_us_q;
              end
              tally <= tally_eff + TALLY_W'(1);
              state <= S_CLK_WIN;
            end
            tmt_pkg::OP_START: begin
              tally     <= '0;
              win_start <= now_us_q;
              last_clk  <= now_us_q;
              state     <= S_IDLE;
            end
            tmt_pkg::OP_STOP: begin
              tally <= '0;
              state <= S_IDLE;
            end
            tmt_pkg::OP_POT: begin
              period_q <= pot_q;
              src_q    <= tmt_pkg::SRC_POT;
              if (pot_q[PERIOD_W-1] || (pot_q == '0) || !pot_hold) begin
                latched <= 1'b0;
                state   <= S_EMIT;
              end else begin
                state <= S_IDLE;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_TAP_RANGE: begin
          state <= out_of_range ? S_IDLE : S_TAP_MEAN;
        end
        S_TAP_MEAN: begin
          state <= S_DIV_WAIT;
        end
        S_CLK_WIN: begin
          if (tally >= cfg.clocks_per_beat) begin
            elapsed_q <= now_us_q - win_start;
            tally     <= '0;
            win_start <= now_us_q;
            state     <= S_CLK_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CLK_DIV: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (div_quo == '0) begin
              state <= S_IDLE;
            end else begin
              latched  <= 1'b1;
              last_ext <= now_ms_q;
              period_q <= div_quo;
              src_q    <= (op_q == tmt_pkg::OP_CLOCK) ? tmt_pkg::SRC_MIDI : tmt_pkg::SRC_TAP;
              state    <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, period_q};
            m_tuser  <= src_q;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/tmt_cfg.sv
// ----------------------------------------------------------------------------
// tmt_cfg
// apb register file holding the tracker settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmt_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmt_pkg::ADDR_W-1:0]  paddr,
  input  logic [tmt_pkg::DATA_W-1:0]  pwdata,
  output logic [tmt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tmt_pkg::cfg_t               cfg
);

  tmt_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = tmt_pkg::reg_idx_t'(paddr[tmt_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_tap_ms       <= tmt_pkg::MIN_TAP_RST;
      cfg.max_tap_ms       <= tmt_pkg::MAX_TAP_RST;
      cfg.decay_ms         <= tmt_pkg::DECAY_RST;
      cfg.clock_timeout_us <= tmt_pkg::TIMEOUT_RST;
      cfg.clocks_per_beat  <= tmt_pkg::CPB_RST;
    end else if (wr_en) begin
      case (idx)
        tmt_pkg::REG_MIN_TAP: cfg.min_tap_ms       <= pwdata[11:0];
        tmt_pkg::REG_MAX_TAP: cfg.max_tap_ms       <= pwdata[11:0];
        tmt_pkg::REG_DECAY:   cfg.decay_ms         <= pwdata[15:0];
        tmt_pkg::REG_TIMEOUT: cfg.clock_timeout_us <= pwdata[23:0];
        tmt_pkg::REG_CPB:     cfg.clocks_per_beat  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tmt_pkg::REG_MIN_TAP: prdata = {20'd0, cfg.min_tap_ms};
      tmt_pkg::REG_MAX_TAP: prdata = {20'd0, cfg.max_tap_ms};
      tmt_pkg::REG_DECAY:   prdata = {16'd0, cfg.decay_ms};
      tmt_pkg::REG_TIMEOUT: prdata = {8'd0, cfg.clock_timeout_us};
      tmt_pkg::REG_CPB:     prdata = {25'd0, cfg.clocks_per_beat};
      default:              prdata = '0;
    endcase
  end

endmodule

### src/tmt_div.sv
// ----------------------------------------------------------------------------
// tmt_div
// reciprocal divider, registered operands and one shared multiply,
// used by both the tap mean and the clock window paths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          wide,
  input  logic                          sat,
  input  logic [tmt_pkg::MUL_W-1:0]     dividend,
  input  logic [tmt_pkg::MUL_W-1:0]     recip,
  output logic                          done,
  output logic [tmt_pkg::PERIOD_W-1:0]  quotient
);

  localparam int MUL_W    = tmt_pkg::MUL_W;
  localparam int PERIOD_W = tmt_pkg::PERIOD_W;
  localparam int PROD_W   = 2 * MUL_W;

  logic [MUL_W-1:0]    opa;
  logic [MUL_W-1:0]    opb;
  logic                wide_q;
  logic                sat_q;
  logic                busy;
  logic [PROD_W-1:0]   prod;
  logic [PERIOD_W-1:0] scaled;

  assign scaled   = wide_q ? prod[tmt_pkg::MS_SHIFT +: PERIOD_W] :
                             prod[tmt_pkg::TAP_SHIFT +: PERIOD_W];
  assign quotient = sat_q ? tmt_pkg::PERIOD_MAX : scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opa    <= dividend;
      opb    <= recip;
      wide_q <= wide;
      sat_q  <= sat;
    end
    if (busy) begin
      prod <= opa * opb;
    end
  end

endmodule

### src/tmt_avg.sv
// ----------------------------------------------------------------------------
// tmt_avg
// tap interval store with fill count and running sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmt_avg #(
  parameter int AVG_DEPTH = tmt_pkg::AVG_DEPTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       clear,
  input  logic                                       write,
  input  logic [tmt_pkg::TAP_W-1:0]                  interval,
  output logic [tmt_pkg::sum_width(AVG_DEPTH)-1:0]   sum,
  output logic [tmt_pkg::fill_width(AVG_DEPTH)-1:0]  fill
);

  localparam int TAP_W  = tmt_pkg::TAP_W;
  localparam int SUM_W  = tmt_pkg::sum_width(AVG_DEPTH);
  localparam int FILL_W = tmt_pkg::fill_width(AVG_DEPTH);
  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  logic [TAP_W-1:0]  store [AVG_DEPTH];
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [SUM_W-1:0]  sum_next;

  assign slot_next = (slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
  assign sum_next  = sum - SUM_W'(store[slot]) + SUM_W'(interval);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      slot <= '0;
      fill <= '0;
      sum  <= '0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        store[i] <= '0;
      end
    end else if (write) begin
      store[slot] <= interval;
      slot        <= slot_next;
      sum         <= sum_next;
      if (fill != FILL_W'(AVG_DEPTH)) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

endmodule

### src/tmt_checker.sv
// ----------------------------------------------------------------------------
// tmt_checker
// port-level checks of the tempo tracker, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tap_and_midi_tempo_tracker_macros.svh"

module tmt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // stalled result holds
  `TMT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // busy after taking a request
  `TMT_ASSERT_NEXT(a_busy_after_req, clk, rst, s_tvalid && s_tready, !s_tready)

  // only defined sources
  `TMT_ASSERT_NOW(a_src_valid, clk, rst, m_tvalid, m_tuser <= tmt_pkg::SRC_POT)

  // external periods are positive and saturated
  `TMT_ASSERT_NOW(a_ext_positive, clk, rst, m_tvalid && (m_tuser != tmt_pkg::SRC_POT), (m_tdata[20:0] != 21'd0) && !m_tdata[20])

endmodule

bind tap_and_midi_tempo_tracker tmt_checker u_checker (.*);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tap and midi tempo tracker: a queue of event
// requests feeds a stream driver, a local tempo predictor builds the expected
// periods on every accepted request, and a monitor compares each result;
// settings are changed over apb between phases while the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tmt_pkg::*;

  localparam int          CYCLE_LIMIT    = 1000000;
  localparam int          SETTLE_CYCLES  = 60;
  localparam int          PHASE_ITEMS    = 235;
  localparam int          HOLD_CYCLES    = 600;
  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] ms;
    logic [31:0] us;
    logic        level;
    logic [20:0] pot;
  } tempo_event_t;

  typedef struct {
    logic [20:0] period;
    src_t        source;
  } tempo_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;  // now_ms, now_us, tap_level, pot_period
  logic [2:0]  s_tuser = '0;  // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;       // period
  logic [1:0]  m_tuser;       // source
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  tap_and_midi_tempo_tracker DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // stimulus and expectations
  tempo_event_t event_queue[$];
  tempo_t       tempo_due[$];
  tempo_event_t cur_ev;
  bit           ev_taken = 0;
  int           accepted_cnt = 0;
  int           errors = 0;
  int           cycles = 0;
  int           phase_items = 0;
  int           hold_left = 0;
  int           hold_at = 32'h7FFF_FFFF;
  bit           hold_done = 0;
  wire          steady = (accepted_cnt >= 300) && (accepted_cnt < 480);

  // predictor copy of settings and state
  cfg_t        tempo_cfg;
  logic [31:0] tap_prev_ms;
  logic [11:0] tap_hist[4];
  int          tap_fill;
  int          tap_slot;
  logic        prev_level;
  logic        ext_hold;
  logic [31:0] ext_ms;
  logic [31:0] win_start_us;
  logic [31:0] last_clk_us;
  logic [6:0]  clk_tally;

  // event time base
  logic [31:0] t_ms;
  logic [31:0] t_us;
  int          us_frac = 0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic void clear_taps();
    tap_fill = 0;
    tap_slot = 0;
    for (int i = 0; i < 4; i++) tap_hist[i] = '0;
  endfunction

  function automatic void reset_tempo_state();
    tempo_cfg.min_tap_ms       = MIN_TAP_RST;
    tempo_cfg.max_tap_ms       = MAX_TAP_RST;
    tempo_cfg.decay_ms         = DECAY_RST;
    tempo_cfg.clock_timeout_us = TIMEOUT_RST;
    tempo_cfg.clocks_per_beat  = CPB_RST;
    tap_prev_ms  = '0;
    clear_taps();
    prev_level   = 1'b1;
    ext_hold     = 1'b0;
    ext_ms       = '0;
    win_start_us = '0;
    last_clk_us  = '0;
    clk_tally    = '0;
  endfunction

  function automatic void emit_tempo(input logic [20:0] p, input src_t s);
    tempo_t t;
    t.period = p;
    t.source = s;
    tempo_due.push_back(t);
  endfunction

  function automatic void offer_period(input logic [31:0] p, input logic [31:0] ms,
                                       input src_t s);
    if (p != 0) begin
      ext_hold = 1'b1;
      ext_ms   = ms;
      emit_tempo(p[20:0], s);
    end
  endfunction

  function automatic void track_tempo(input tempo_event_t ev);
    logic [31:0] iv;
    logic [31:0] sum;
    logic [31:0] mean;
    logic [31:0] elapsed;
    logic [63:0] q;
    case (ev.op)
      OP_TAP: begin
        if (prev_level && !ev.level) begin
          if (tap_prev_ms != 0) begin
            iv = ev.ms - tap_prev_ms;
            if (iv < tempo_cfg.min_tap_ms || iv > tempo_cfg.max_tap_ms) begin
              clear_taps();
            end else begin
              tap_hist[tap_slot] = iv[11:0];
              tap_slot = (tap_slot + 1) % 4;
              if (tap_fill < 4) tap_fill++;
              sum = 0;
              for (int i = 0; i < tap_fill; i++) sum += tap_hist[i];
              mean = (sum * 16 + tap_fill / 2) / tap_fill;
              if (mean > PERIOD_MAX) mean = PERIOD_MAX;
              offer_period(mean, ev.ms, SRC_TAP);
            end
          end
          tap_prev_ms = ev.ms;
        end
        prev_level = ev.level;
      end
      OP_CLOCK: begin
        if (last_clk_us != 0 && (ev.us - last_clk_us) > tempo_cfg.clock_timeout_us)
          clk_tally = '0;
        last_clk_us = ev.us;
        if (clk_tally == 0) win_start_us = ev.us;
        clk_tally = clk_tally + 7'd1;
        if (clk_tally >= tempo_cfg.clocks_per_beat) begin
          elapsed = ev.us - win_start_us;
          q = ({32'd0, elapsed} * 64'd16 + 64'd500) / 64'd1000;
          if (q > PERIOD_MAX) q = PERIOD_MAX;
          clk_tally = '0;
          win_start_us = ev.us;
          offer_period(q[31:0], ev.ms, SRC_MIDI);
        end
      end
      OP_START: begin
        clk_tally    = '0;
        win_start_us = ev.us;
        last_clk_us  = ev.us;
      end
      OP_STOP: clk_tally = '0;
      OP_POT: begin
        if (ev.pot[20] || ev.pot == 0) begin
          ext_hold = 1'b0;
          emit_tempo(ev.pot, SRC_POT);
        end else if (!(ext_hold && (ev.ms - ext_ms) <= tempo_cfg.decay_ms)) begin
          ext_hold = 1'b0;
          emit_tempo(ev.pot, SRC_POT);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(input reg_idx_t idx);
    case (idx)
      REG_MIN_TAP: return {20'd0, tempo_cfg.min_tap_ms};
      REG_MAX_TAP: return {20'd0, tempo_cfg.max_tap_ms};
      REG_DECAY:   return {16'd0, tempo_cfg.decay_ms};
      REG_TIMEOUT: return {8'd0, tempo_cfg.clock_timeout_us};
      REG_CPB:     return {25'd0, tempo_cfg.clocks_per_beat};
      default:     return '0;
    endcase
  endfunction

  // stream driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || ev_taken) begin
      ev_taken = 0;
      if (event_queue.size() > 0 && (steady || $urandom_range(0, 99) >= 24)) begin
        cur_ev = event_queue.pop_front();
        s_tdata  <= {2'b00, cur_ev.pot, cur_ev.level, cur_ev.us, cur_ev.ms};
        s_tuser  <= cur_ev.op;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= 24);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (!hold_done && accepted_cnt >= hold_at) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
  end

  // accept and compare
  always @(posedge clk) begin
    tempo_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        track_tempo(cur_ev);
        ev_taken = 1;
        accepted_cnt++;
      end
      if (m_tvalid && m_tready) begin
        if (tempo_due.size() == 0) begin
          flag_mismatch("unexpected result", {8'd0, m_tdata}, '0);
        end else begin
          want = tempo_due.pop_front();
          if (m_tdata[20:0] !== want.period)
            flag_mismatch("period", {11'd0, m_tdata[20:0]}, {11'd0, want.period});
          if (m_tuser !== want.source)
            flag_mismatch("source", {30'd0, m_tuser}, {30'd0, want.source});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_event(input logic [2:0] op, input logic [31:0] ms,
                            input logic [31:0] us, input logic level,
                            input logic [20:0] pot);
    tempo_event_t ev;
    ev.op = op;
    ev.ms = ms;
    ev.us = us;
    ev.level = level;
    ev.pot = pot;
    event_queue.push_back(ev);
    if (op <= OP_POT) phase_items++;
  endtask

  task automatic advance_us(input logic [31:0] d);
    t_us = t_us + d;
    us_frac += d % 1000;
    t_ms = t_ms + d / 1000 + us_frac / 1000;
    us_frac = us_frac % 1000;
  endtask

  task automatic gen_taps();
    int n;
    int d;
    n = $urandom_range(2, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8 && tempo_cfg.min_tap_ms <= tempo_cfg.max_tap_ms)
        d = $urandom_range(tempo_cfg.min_tap_ms, tempo_cfg.max_tap_ms);
      else
        d = $urandom_range(0, 5000);
      advance_us((d / 2) * 1000);
      push_event(OP_TAP, t_ms, t_us, 1'b1, 21'($urandom));
      if ($urandom_range(0, 4) == 0) push_event(OP_TAP, t_ms, t_us, 1'b1, '0);
      advance_us((d - d / 2) * 1000);
      push_event(OP_TAP, t_ms, t_us, 1'b0, 21'($urandom));
      if ($urandom_range(0, 4) == 0) push_event(OP_TAP, t_ms, t_us, 1'b0, '0);
    end
  endtask

  task automatic gen_midi();
    int k;
    int sp;
    logic [31:0] tmo;
    tmo = tempo_cfg.clock_timeout_us;
    if ($urandom_range(0, 1) == 0) push_event(OP_START, t_ms, t_us, 1'b1, '0);
    if ($urandom_range(0, 9) == 0 && tmo >= 40000)
      sp = $urandom_range(tmo / 2, tmo);
    else
      sp = $urandom_range(300, 40000);
    k = tempo_cfg.clocks_per_beat * $urandom_range(1, 2) + $urandom_range(1, 4);
    if (k > 150) k = 150;
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 99) < 3)
        advance_us(tmo + 1 + $urandom_range(0, 5000));
      else
        advance_us(sp + $urandom_range(0, sp / 8));
      if ($urandom_range(0, 99) < 2)
        push_event(OP_STOP, t_ms, t_us, 1'b0, '0);
      else
        push_event(OP_CLOCK, t_ms, t_us, 1'($urandom), 21'($urandom));
    end
  endtask

  task automatic gen_pot();
    int gap;
    int kind;
    logic [20:0] p;
    gap = $urandom_range(0, tempo_cfg.decay_ms + 3000);
    advance_us(gap * 1000);
    kind = $urandom_range(0, 19);
    if (kind < 14) p = {1'b0, 20'($urandom_range(1, 20'hFFFFF))};
    else if (kind < 18) p = {1'b1, 20'($urandom)};
    else p = '0;
    push_event(OP_POT, t_ms, t_us, 1'($urandom), p);
  endtask

  task automatic fill_random();
    int pick;
    phase_items = 0;
    if ($urandom_range(0, 2) == 0) begin
      t_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      t_us = 32'hFFFF_FFFF - $urandom_range(0, 20000000);
    end else begin
      t_ms = $urandom;
      t_us = $urandom;
    end
    while (phase_items < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) gen_taps();
      else if (pick < 60) gen_midi();
      else if (pick < 90) gen_pot();
      else push_event(3'($urandom), $urandom, $urandom, 1'($urandom), 21'($urandom));
    end
  endtask

  task automatic settle();
    while (event_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (tempo_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (wr) begin
      case (idx)
        REG_MIN_TAP: tempo_cfg.min_tap_ms       = val[11:0];
        REG_MAX_TAP: tempo_cfg.max_tap_ms       = val[11:0];
        REG_DECAY:   tempo_cfg.decay_ms         = val[15:0];
        REG_TIMEOUT: tempo_cfg.clock_timeout_us = val[23:0];
        REG_CPB:     tempo_cfg.clocks_per_beat  = val[6:0];
        default: ;
      endcase
    end else if (prdata !== reg_value(idx)) begin
      flag_mismatch("register readback", prdata, reg_value(idx));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_phase(input logic [31:0] min_ms, input logic [31:0] max_ms,
                               input logic [31:0] decay, input logic [31:0] tmo,
                               input logic [31:0] cpb);
    settle();
    apb_access(REG_MIN_TAP, 1'b1, min_ms);
    apb_access(REG_MAX_TAP, 1'b1, max_ms);
    apb_access(REG_DECAY,   1'b1, decay);
    apb_access(REG_TIMEOUT, 1'b1, tmo);
    apb_access(REG_CPB,     1'b1, cpb);
    apb_access(REG_MIN_TAP, 1'b0, '0);
    apb_access(REG_MAX_TAP, 1'b0, '0);
    apb_access(REG_DECAY,   1'b0, '0);
    apb_access(REG_TIMEOUT, 1'b0, '0);
    apb_access(REG_CPB,     1'b0, '0);
  endtask

  initial begin
    reset_tempo_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: time zero tap, tap limits, wrap, pot priority, control codes
    push_event(OP_TAP, 32'd0, 32'd0, 1'b1, '0);
    push_event(OP_TAP, 32'd0, 32'd0, 1'b0, '0);
    push_event(OP_TAP, 32'd100, 32'd100000, 1'b1, '0);
    push_event(OP_TAP, 32'd500, 32'd500000, 1'b0, '0);
    push_event(OP_TAP, 32'd700, 32'd700000, 1'b1, '0);
    push_event(OP_TAP, 32'd2500, 32'd2500000, 1'b0, '0);
    push_event(OP_TAP, 32'd2600, 32'd2600000, 1'b1, '0);
    push_event(OP_TAP, 32'd2620, 32'd2620000, 1'b0, '0);
    push_event(OP_TAP, 32'd2630, 32'd2630000, 1'b0, 21'h1FFFFF);
    push_event(OP_TAP, 32'd2700, 32'd2700000, 1'b1, '0);
    push_event(OP_TAP, 32'd2679, 32'd2679000, 1'b0, '0);
    push_event(OP_TAP, 32'd2800, 32'd2800000, 1'b1, '0);
    push_event(OP_TAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
    push_event(OP_TAP, 32'd10, 32'd10000, 1'b1, '0);
    push_event(OP_TAP, 32'd99, 32'd99000, 1'b0, '0);
    push_event(OP_POT, 32'd200, 32'd200000, 1'b1, 21'h0FFFFF);
    push_event(OP_POT, 32'd300, 32'd300000, 1'b1, 21'h100000);
    push_event(OP_POT, 32'd400, 32'd400000, 1'b1, 21'h000000);
    push_event(OP_POT, 32'd500, 32'd500000, 1'b1, 21'h0FFFFF);
    push_event(OP_START, 32'd600, 32'hFFFF_FFF0, 1'b1, '0);
    push_event(OP_CLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 21'h1FFFFF);
    push_event(OP_STOP, 32'd700, 32'd0, 1'b0, '0);
    push_event(OP_SPARE_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 21'h1FFFFF);
    push_event(OP_SPARE_FIRST + 3'd1, 32'd0, 32'd0, 1'b0, '0);
    push_event(OP_SPARE_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 21'h1FFFFF);
    fill_random();

    // widest tap range, no decay, longest timeout, one clock per window
    program_phase(32'd1, 32'd4095, 32'd0, 32'hFF_FFFF, 32'd1);
    fill_random();

    // inverted tap range, longest decay, zero timeout, window wider than the default
    program_phase(32'd4095, 32'd1, 32'hFFFF, 32'd0, 32'd96);
    fill_random();

    // short windows with the receiver held off for a long stretch
    program_phase(32'd40, 32'd1500, 32'd1000, 32'd50000, 32'd4);
    hold_at = accepted_cnt + 40;
    fill_random();

    // single accepted interval and saturating slow windows
    program_phase(32'd100, 32'd100, 32'd3000, 32'hFF_FFFF, 32'd24);
    fill_random();

    // zero clocks per beat with random limits
    program_phase($urandom_range(1, 300), $urandom_range(300, 4095),
                  $urandom_range(0, 65535), $urandom_range(20000, 3000000), 32'd0);
    fill_random();

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
